### rtl/core/gbf_pkg.sv
// Package for the grayscale bilateral filter.
// Holds the sequencer state type, register indexes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbf_pkg;

  localparam int CFG_W      = 11;
  localparam int IDX_W      = 2;
  localparam int PIX_W      = 8;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CENTRE,
    ST_TAPS,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_DIV,
    ST_DONE
  } gbf_state_t;

endpackage
`default_nettype wire

### rtl/core/gbf_if.sv
// Stream interfaces of the bilateral filter: pixel input and result output.
// Depends on gbf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface gbf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [gbf_pkg::PIX_W-1:0] pixel_value;
  modport source (output valid, command, pixel_value, input ready);
  modport sink   (input valid, command, pixel_value, output ready);
endinterface

interface gbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [gbf_pkg::PIX_W-1:0] filtered_value;
  logic                      frame_done;
  modport source (output valid, filtered_value, frame_done, input ready);
  modport sink   (input valid, filtered_value, frame_done, output ready);
endinterface
`default_nettype wire

### rtl/core/grayscale_bilateral_filter_top.sv
// Top level of the streaming grayscale bilateral filter.
// Depends on gbf_pkg, gbf_if and gbf_ram.
`timescale 1ns / 1ps
`default_nettype none
// Pixels arrive in raster order (command 0); each push that completes a window
// starts one filtered output at a lag of radius*width+radius pixels, and drain
// commands (command 1) flush the rest once the frame is in. An output is computed
// one window tap per cycle through the row store read port and the shared weight
// multiply-accumulate, then by an 8-step restoring divide. Input is not ready
// while an output is being computed. The row store holds
// (2*MAX_RADIUS+1)*MAX_WIDTH pixels and needs no clearing. A write to any of
// the three configuration registers restarts the frame.
module grayscale_bilateral_filter_top #(
  parameter int MAX_WIDTH          = 1024,
  parameter int MAX_RADIUS         = 7,
  parameter int SIGMA_SPACE_TENTHS = 100,
  parameter int SIGMA_RANGE_TENTHS = 125
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  gbf_in_if.sink                            pixels,
  gbf_out_if.source                         results,
  input  wire logic                         write_enable,
  input  wire logic [gbf_pkg::IDX_W-1:0]    reg_index,
  input  wire logic [gbf_pkg::CFG_W-1:0]    write_data
);
  localparam int STORE      = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int ABITS      = $clog2(STORE);
  localparam int EW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(gbf_pkg::MAX_HEIGHT + 1);
  localparam int CNT_W      = $clog2(MAX_WIDTH * gbf_pkg::MAX_HEIGHT + 1);
  localparam int SW         = CNT_W + 2;
  localparam int RB         = $clog2(MAX_RADIUS + 1);
  localparam int DW         = RB + 1;
  localparam int SPACE_SIZE = 2 * MAX_RADIUS * MAX_RADIUS + 1;
  localparam int D2W        = $clog2(SPACE_SIZE);
  localparam int TAPS       = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NORM_W     = 16 + $clog2(TAPS + 1);
  localparam int ACC_W      = NORM_W + gbf_pkg::PIX_W;
  localparam longint unsigned SPACE_DEN = SIGMA_SPACE_TENTHS * SIGMA_SPACE_TENTHS;
  localparam longint unsigned RANGE_DEN = SIGMA_RANGE_TENTHS * SIGMA_RANGE_TENTHS;
  localparam longint unsigned INV_E_Q32 = 64'd1580030169;

  typedef logic [15:0] space_rom_t [SPACE_SIZE];
  typedef logic [15:0] range_rom_t [256];

  // shift-and-subtract quotient, used only while building the tables
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] gauss_q16(longint unsigned q, logic use_range);
    longint unsigned num, den, k, frac, term, v, r;
    longint          sum;
    num = 64'd50 * q;
    den = use_range ? RANGE_DEN : SPACE_DEN;
    k   = udiv(num, den);
    if (k >= 16) begin
      return 16'd0;
    end
    frac = udiv((num - k * den) << 32, den);
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int i = 1; i <= 24; i++) begin
      term = udiv((term * frac) >> 32, 64'(i));
      if (i[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(64'd1 << 32)) sum = longint'(64'd1 << 32);
    v = longint'(sum);
    for (int i = 0; i < 16; i++) begin
      if (i < int'(k)) v = (v * INV_E_Q32) >> 32;
    end
    r = (v + 64'd32768) >> 16;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic space_rom_t build_space();
    space_rom_t t;
    for (int i = 0; i < SPACE_SIZE; i++) t[i] = gauss_q16(longint'(i), 1'b0);
    return t;
  endfunction

  function automatic range_rom_t build_range();
    range_rom_t t;
    for (int i = 0; i < 256; i++) t[i] = gauss_q16(longint'(i * i), 1'b1);
    return t;
  endfunction

  localparam space_rom_t SPACE_ROM = build_space();
  localparam range_rom_t RANGE_ROM = build_range();

  // configuration
  logic [gbf_pkg::CFG_W-1:0] cfg_width, cfg_height;
  logic [2:0]                cfg_radius;
  logic [EW-1:0]             ew;
  logic [HW-1:0]             eh;
  logic [RB-1:0]             er;
  logic [CNT_W-1:0]          total, lag;

  always_comb begin
    if (cfg_width == '0)                 ew = EW'(1);
    else if (32'(cfg_width) > MAX_WIDTH) ew = EW'(MAX_WIDTH);
    else                                 ew = EW'(cfg_width);
    if (cfg_height == '0)                               eh = HW'(1);
    else if (32'(cfg_height) > gbf_pkg::MAX_HEIGHT)     eh = HW'(gbf_pkg::MAX_HEIGHT);
    else                                                eh = HW'(cfg_height);
    if (32'(cfg_radius) > MAX_RADIUS) er = RB'(MAX_RADIUS);
    else                              er = RB'(cfg_radius);
    total = CNT_W'(ew) * CNT_W'(eh);
    lag   = CNT_W'(er) * CNT_W'(ew) + CNT_W'(er);
  end

  // registers
  gbf_pkg::gbf_state_t       state, state_next;
  logic [CNT_W-1:0]          rcv, emt;
  logic [ABITS-1:0]          waddr, caddr;
  logic [HW-1:0]             erow;
  logic [EW-1:0]             ecol;
  logic signed [DW-1:0]      dx, dy;
  logic signed [SW-1:0]      row_off;
  logic [gbf_pkg::PIX_W-1:0] centre;
  logic                      s1_valid, s2_valid;
  logic [15:0]               s1_sw, s2_wt;
  logic [gbf_pkg::PIX_W-1:0] s2_p;
  logic [ACC_W-1:0]          acc, rem;
  logic [NORM_W-1:0]         norm;
  logic [2:0]                bit_idx;
  logic [gbf_pkg::PIX_W-1:0] quot;
  logic                      out_valid, out_done;
  logic [gbf_pkg::PIX_W-1:0] out_value;

  // input decode
  logic in_fire, push_ok, emit_go;
  logic [CNT_W-1:0] rcv_inc;
  assign in_fire = pixels.valid && pixels.ready;
  assign rcv_inc = rcv + CNT_W'(1);
  assign push_ok = (pixels.command == gbf_pkg::CMD_PUSH) && (rcv < total);
  assign emit_go = (push_ok && ({1'b0, rcv_inc} > {1'b0, emt} + {1'b0, lag})) ||
                   ((pixels.command == gbf_pkg::CMD_DRAIN) && (rcv >= total) && (emt < total));

  // tap address and bounds
  logic signed [SW-1:0] yy, xx, off, taddr;
  logic                 inb, last_dx, last_dy;
  logic [ABITS-1:0]     tap_addr;
  logic [RB-1:0]        ax, ay;
  logic [D2W-1:0]       d2;
  always_comb begin
    yy    = SW'($signed({1'b0, erow})) + SW'(dy);
    xx    = SW'($signed({1'b0, ecol})) + SW'(dx);
    inb   = (yy >= 0) && (xx >= 0) && (yy < SW'($signed({1'b0, eh}))) &&
            (xx < SW'($signed({1'b0, ew})));
    off   = row_off + SW'(dx);
    taddr = SW'($signed({1'b0, caddr})) + off;
    if (taddr < 0)                 taddr = taddr + SW'(STORE);
    else if (taddr >= SW'(STORE))  taddr = taddr - SW'(STORE);
    tap_addr = taddr[ABITS-1:0];
    ax = (dx < 0) ? RB'(-dx) : RB'(dx);
    ay = (dy < 0) ? RB'(-dy) : RB'(dy);
    d2 = D2W'(ax * ax) + D2W'(ay * ay);
    last_dx = (dx == DW'($signed({1'b0, er})));
    last_dy = (dy == DW'($signed({1'b0, er})));
  end

  // row store
  logic                      ram_we;
  logic [ABITS-1:0]          ram_raddr;
  logic [gbf_pkg::PIX_W-1:0] ram_rdata;
  gbf_ram #(.WIDTH(gbf_pkg::PIX_W), .DEPTH(STORE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (pixels.pixel_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // range weight and divide step
  logic [gbf_pkg::PIX_W-1:0] diff;
  logic [31:0]               wprod;
  logic [ACC_W-1:0]          dsh;
  always_comb begin
    diff  = (ram_rdata > centre) ? ram_rdata - centre : centre - ram_rdata;
    wprod = s1_sw * RANGE_ROM[diff];
    dsh   = ACC_W'(norm) << bit_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbf_pkg::ST_IDLE:   if (in_fire && emit_go) state_next = gbf_pkg::ST_SETUP;
      gbf_pkg::ST_SETUP:  state_next = gbf_pkg::ST_CENTRE;
      gbf_pkg::ST_CENTRE: state_next = gbf_pkg::ST_TAPS;
      gbf_pkg::ST_TAPS:   if (last_dx && last_dy) state_next = gbf_pkg::ST_FLUSH1;
      gbf_pkg::ST_FLUSH1: state_next = gbf_pkg::ST_FLUSH2;
      gbf_pkg::ST_FLUSH2: state_next = gbf_pkg::ST_DIV;
      gbf_pkg::ST_DIV:    if (bit_idx == '0) state_next = gbf_pkg::ST_DONE;
      gbf_pkg::ST_DONE:   state_next = gbf_pkg::ST_IDLE;
      default:            state_next = gbf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pixels.ready = (state == gbf_pkg::ST_IDLE) && (!out_valid || results.ready);
    ram_we       = in_fire && push_ok;
    ram_raddr    = (state == gbf_pkg::ST_TAPS) ? tap_addr : caddr;
    results.valid          = out_valid;
    results.filtered_value = out_value;
    results.frame_done     = out_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbf_pkg::ST_IDLE;
      cfg_width  <= gbf_pkg::CFG_W'(640);
      cfg_height <= gbf_pkg::CFG_W'(480);
      cfg_radius <= 3'd7;
      rcv        <= '0;
      emt        <= '0;
      waddr      <= '0;
      caddr      <= '0;
      erow       <= '0;
      ecol       <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == gbf_pkg::ST_TAPS) && inb;
      s2_valid <= s1_valid;
      if (results.valid && results.ready) out_valid <= 1'b0;

      if (write_enable) begin
        unique case (reg_index)
          gbf_pkg::REG_FRAME_WIDTH:   cfg_width  <= write_data;
          gbf_pkg::REG_FRAME_HEIGHT:  cfg_height <= write_data;
          gbf_pkg::REG_WINDOW_RADIUS: cfg_radius <= write_data[2:0];
          default: ;
        endcase
        if (reg_index == gbf_pkg::REG_FRAME_WIDTH || reg_index == gbf_pkg::REG_FRAME_HEIGHT ||
            reg_index == gbf_pkg::REG_WINDOW_RADIUS) begin
          rcv   <= '0;
          emt   <= '0;
          waddr <= '0;
          caddr <= '0;
          erow  <= '0;
          ecol  <= '0;
        end
      end

      if (ram_we) begin
        rcv   <= rcv_inc;
        waddr <= (32'(waddr) == STORE - 1) ? '0 : waddr + ABITS'(1);
      end

      if (state == gbf_pkg::ST_DONE) begin
        out_valid <= 1'b1;
        out_value <= (norm == '0) ? centre : quot;
        if (emt + CNT_W'(1) >= total) begin
          out_done <= 1'b1;
          rcv      <= '0;
          emt      <= '0;
          waddr    <= '0;
          caddr    <= '0;
          erow     <= '0;
          ecol     <= '0;
        end else begin
          out_done <= 1'b0;
          emt      <= emt + CNT_W'(1);
          caddr    <= (32'(caddr) == STORE - 1) ? '0 : caddr + ABITS'(1);
          if (ecol + EW'(1) == ew) begin
            ecol <= '0;
            erow <= erow + HW'(1);
          end else begin
            ecol <= ecol + EW'(1);
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    s1_sw <= SPACE_ROM[d2];
    s2_wt <= wprod[31:16];
    s2_p  <= ram_rdata;
    unique case (state)
      gbf_pkg::ST_SETUP: begin
        dx      <= -DW'($signed({1'b0, er}));
        dy      <= -DW'($signed({1'b0, er}));
        row_off <= -(SW'(er) * SW'(ew));
        acc     <= '0;
        norm    <= '0;
      end
      gbf_pkg::ST_CENTRE: centre <= ram_rdata;
      gbf_pkg::ST_TAPS: begin
        if (last_dx) begin
          dx      <= -DW'($signed({1'b0, er}));
          dy      <= dy + DW'(1);
          row_off <= row_off + SW'(ew);
        end else begin
          dx <= dx + DW'(1);
        end
      end
      gbf_pkg::ST_FLUSH2: begin
        bit_idx <= 3'd7;
        quot    <= '0;
      end
      gbf_pkg::ST_DIV: begin
        if (rem >= dsh) begin
          rem           <= rem - dsh;
          quot[bit_idx] <= 1'b1;
        end
        bit_idx <= bit_idx - 3'd1;
      end
      default: ;
    endcase
    if (s2_valid) begin
      acc  <= acc + ACC_W'(s2_p * s2_wt);
      norm <= norm + NORM_W'(s2_wt);
    end
    if (state == gbf_pkg::ST_FLUSH2) begin
      rem <= s2_valid ? acc + ACC_W'(s2_p * s2_wt) : acc;
    end
  end
endmodule
`default_nettype wire

### rtl/core/gbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
